>>> rtl/mmp_pkg.sv
// ----------------------------------------------------------------------------
// MIDI message parser package
// Types, byte constants and the data-byte count table that the parser's
// files have in common.
// ----------------------------------------------------------------------------
package mmp_pkg;

  // Kinds of result item.
  typedef enum logic [1:0] {
    KIND_SHORT   = 2'd0,
    KIND_SXBYTE  = 2'd1,
    KIND_SXEND   = 2'd2,
    KIND_SXABORT = 2'd3
  } kind_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYSEX_ENABLE = 1'd1;

  // Byte codes on the serial line.
  localparam logic [7:0] BYTE_REALTIME_MIN = 8'hF8;
  localparam logic [7:0] BYTE_SYSEX_START  = 8'hF0;
  localparam logic [7:0] BYTE_SYSEX_END    = 8'hF7;
  localparam logic [7:0] BYTE_MTC_QUARTER  = 8'hF1;
  localparam logic [7:0] BYTE_SONG_POS     = 8'hF2;
  localparam logic [7:0] BYTE_SONG_SELECT  = 8'hF3;
  localparam logic [3:0] HI_NOTE_OFF       = 4'h8;
  localparam logic [3:0] HI_NOTE_ON        = 4'h9;
  localparam logic [3:0] HI_POLY_PRESSURE  = 4'hA;
  localparam logic [3:0] HI_CONTROL        = 4'hB;
  localparam logic [3:0] HI_PROGRAM        = 4'hC;
  localparam logic [3:0] HI_CHAN_PRESSURE  = 4'hD;
  localparam logic [3:0] HI_PITCH_BEND     = 4'hE;
  localparam logic [3:0] HI_SYSTEM         = 4'hF;

  localparam int unsigned LEN_W = 11;

  // Enable bits held in the configuration registers.
  typedef struct packed {
    logic short_enable;
    logic sysex_enable;
  } cfg_t;

  // Running-status part of the parser state.
  typedef struct packed {
    logic       in_sysex;
    logic [7:0] running_status;
    logic [1:0] data_remaining;
    logic [6:0] held_data;
  } parse_state_t;

  // One result item.
  typedef struct packed {
    kind_t            kind;
    logic [7:0]       status_byte;
    logic [6:0]       data_first;
    logic [6:0]       data_second;
    logic [7:0]       sysex_byte;
    logic             byte_valid;
    logic [LEN_W-1:0] sysex_length;
  } msg_t;

  // Number of data bytes that follow a status byte.
  function automatic logic [1:0] data_count_for(input logic [7:0] s);
    logic [1:0] n;
    case (s[7:4])
      HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_PRESSURE, HI_CONTROL, HI_PITCH_BEND: n = 2'd2;
      HI_PROGRAM, HI_CHAN_PRESSURE: n = 2'd1;
      HI_SYSTEM: begin
        if (s == BYTE_MTC_QUARTER || s == BYTE_SONG_SELECT) n = 2'd1;
        else if (s == BYTE_SONG_POS) n = 2'd2;
        else n = 2'd0;
      end
      default: n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/mmp_if.sv
// ----------------------------------------------------------------------------
// MIDI message parser channels
// Valid/ready channels for received bytes, result items and register writes.
// ----------------------------------------------------------------------------

// Received byte channel.
interface mmp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Result item channel.
interface mmp_msg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  status_byte;
  logic [6:0]  data_first;
  logic [6:0]  data_second;
  logic [7:0]  sysex_byte;
  logic        byte_valid;
  logic [10:0] sysex_length;

  modport source (output valid, output kind, output status_byte, output data_first,
                  output data_second, output sysex_byte, output byte_valid,
                  output sysex_length, input ready);
  modport sink (input valid, input kind, input status_byte, input data_first,
                input data_second, input sysex_byte, input byte_valid,
                input sysex_length, output ready);
endinterface

// Register write channel.
interface mmp_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [0:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/mmp_step.sv
// ----------------------------------------------------------------------------
// MIDI message parser step logic
// Decodes one byte against the parser state: gives the next state and at
// most one result item.
// ----------------------------------------------------------------------------
module mmp_step #(
  parameter int unsigned SYSEX_CAPACITY = 1024
) (
  input  logic [7:0]                            rx_byte,
  input  mmp_pkg::cfg_t                         cfg,
  input  mmp_pkg::parse_state_t                 state,
  input  logic [$clog2(SYSEX_CAPACITY+1)-1:0]   count,
  output mmp_pkg::parse_state_t                 state_next,
  output logic [$clog2(SYSEX_CAPACITY+1)-1:0]   count_next,
  output logic                                  emit,
  output mmp_pkg::msg_t                         msg
);
  import mmp_pkg::*;

  localparam int unsigned CNT_W = $clog2(SYSEX_CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(SYSEX_CAPACITY);

  logic             room;
  logic [CNT_W-1:0] count_inc;

  assign room      = (count < CAP);
  assign count_inc = count + CNT_W'(1);

  // Byte classification and state update.
  always_comb begin
    state_next = state;
    count_next = count;
    emit       = 1'b0;
    msg        = '0;
    msg.kind   = KIND_SHORT;

    if (rx_byte >= BYTE_REALTIME_MIN) begin
      // Real-time bytes pass by without effect.
    end else if (rx_byte == BYTE_SYSEX_START) begin
      // Start, or restart, of a packet.
      state_next.in_sysex       = 1'b1;
      state_next.running_status = '0;
      count_next                = CNT_W'(1);
      emit                      = cfg.sysex_enable;
      msg.kind                  = KIND_SXBYTE;
      msg.sysex_byte            = rx_byte;
      msg.byte_valid            = 1'b1;
      msg.sysex_length          = LEN_W'(1);
    end else if (rx_byte == BYTE_SYSEX_END) begin
      // End of a packet; the end byte is kept only when it still fits.
      if (state.in_sysex) begin
        state_next.in_sysex = 1'b0;
        count_next          = '0;
        emit                = cfg.sysex_enable;
        msg.kind            = KIND_SXEND;
        msg.sysex_byte      = room ? rx_byte : 8'h00;
        msg.byte_valid      = room;
        msg.sysex_length    = LEN_W'(room ? count_inc : count);
      end
    end else if (state.in_sysex) begin
      // Payload byte, or abort when the packet is full.
      if (room) begin
        count_next       = count_inc;
        emit             = cfg.sysex_enable;
        msg.kind         = KIND_SXBYTE;
        msg.sysex_byte   = rx_byte;
        msg.byte_valid   = 1'b1;
        msg.sysex_length = LEN_W'(count_inc);
      end else begin
        state_next.in_sysex = 1'b0;
        count_next          = '0;
        emit                = cfg.sysex_enable;
        msg.kind            = KIND_SXABORT;
        msg.sysex_length    = LEN_W'(count);
      end
    end else if (rx_byte[7]) begin
      // New status byte; a status with no data bytes goes out at once.
      state_next.running_status = rx_byte;
      state_next.data_remaining = data_count_for(rx_byte);
      state_next.held_data      = '0;
      if (data_count_for(rx_byte) == 2'd0) begin
        emit            = cfg.short_enable;
        msg.status_byte = rx_byte;
      end
    end else if (state.running_status != 8'h00) begin
      // Data byte under running status; orphans are dropped.
      if (state.data_remaining == 2'd2) begin
        state_next.held_data      = rx_byte[6:0];
        state_next.data_remaining = 2'd1;
      end else if (state.data_remaining == 2'd1) begin
        state_next.data_remaining = data_count_for(state.running_status);
        state_next.held_data      = '0;
        emit                      = cfg.short_enable;
        msg.status_byte           = state.running_status;
        msg.data_first            = state.held_data;
        msg.data_second           = rx_byte[6:0];
      end
    end
  end

endmodule

>>> rtl/mmp_out_reg.sv
// ----------------------------------------------------------------------------
// MIDI message parser result register
// Holds one result item until the sink takes it; reloads in the same cycle.
// ----------------------------------------------------------------------------
module mmp_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  mmp_pkg::msg_t  msg_in,
  output logic           free,
  mmp_msg_if.source      result
);
  import mmp_pkg::*;

  logic valid;
  msg_t held;

  assign free = !valid || result.ready;

  // Valid flag of the held request.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (free) begin
      valid <= load;
    end
  end

  // Payload, loaded with no reset.
  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= msg_in;
    end
  end

  assign result.valid        = valid;
  assign result.kind         = held.kind;
  assign result.status_byte  = held.status_byte;
  assign result.data_first   = held.data_first;
  assign result.data_second  = held.data_second;
  assign result.sysex_byte   = held.sysex_byte;
  assign result.byte_valid   = held.byte_valid;
  assign result.sysex_length = held.sysex_length;

endmodule

>>> rtl/midi_message_parser.sv
// ----------------------------------------------------------------------------
// MIDI message parser
// A byte accepted into the input register is decoded by the step logic; its
// result is loaded into the result register and offered from there.
// Throughput: one byte per cycle while the result register has room, set by
// the single decode stage between the input register and the result register.
// Reset clears the parser state and both enable registers; no clearing pass.
// ----------------------------------------------------------------------------
module midi_message_parser #(
  parameter int unsigned SYSEX_CAPACITY = 1024
) (
  input  logic       clk,
  input  logic       rst,
  mmp_rx_if.sink     rx,
  mmp_msg_if.source  result,
  mmp_cfg_if.sink    cfg
);
  import mmp_pkg::*;

  localparam int unsigned CNT_W = $clog2(SYSEX_CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(SYSEX_CAPACITY);

  cfg_t         enables;
  logic         in_valid;
  logic [7:0]   in_byte;
  parse_state_t state;
  parse_state_t state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic         emit;
  msg_t         step_msg;
  logic         out_free;
  logic         advance;

  // Register writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enables <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SHORT_ENABLE: enables.short_enable <= cfg.data[0];
        REG_SYSEX_ENABLE: enables.sysex_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // The held byte moves on unless its result finds the result register full.
  assign advance  = in_valid && (!emit || out_free);
  assign rx.ready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      in_byte <= rx.rx_byte;
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
      count <= '0;
    end else if (advance) begin
      state <= state_next;
      count <= count_next;
    end
  end

  mmp_step #(
    .SYSEX_CAPACITY(SYSEX_CAPACITY)
  ) u_step (
    .rx_byte    (in_byte),
    .cfg        (enables),
    .state      (state),
    .count      (count),
    .state_next (state_next),
    .count_next (count_next),
    .emit       (emit),
    .msg        (step_msg)
  );

  mmp_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && emit),
    .msg_in (step_msg),
    .free   (out_free),
    .result (result)
  );

  // The packet length never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CAP)
    else $error("packet length beyond capacity");

  // Outside a packet the length counter rests at zero.
  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    !state.in_sysex |-> count == '0)
    else $error("length counter not cleared outside a packet");

  // A short message always carries a status byte.
  a_short_status: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.kind == KIND_SHORT) |-> result.status_byte[7])
    else $error("short message without a status byte");

  // A held byte that is stalled keeps the parser state unchanged.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> $stable(state) && $stable(count))
    else $error("parser state moved while the byte was stalled");

endmodule

>>> dv/mmp_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI message parser result checker
// Watches the byte, result and register-write channels, keeps its own copy of
// the parser state and enables, predicts the result of every accepted byte
// and compares each accepted result field by field with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module mmp_result_checker
  import mmp_pkg::*;
#(
  parameter int unsigned SYSEX_CAPACITY = 1024
) (
  input  logic        clk,
  input  logic        rst,
  mmp_rx_if           rx,
  mmp_msg_if          result,
  mmp_cfg_if          cfg,
  output int unsigned errors,
  output int unsigned outstanding
);

  localparam logic [7:0] STATUS_NONE = 8'h00;
  localparam int unsigned REPORT_MAX = 10;

  // Copy of the enables and of the parser state.
  cfg_t        en;
  logic        in_packet;
  int unsigned packet_len;
  logic [7:0]  run_status;
  logic [1:0]  data_left;
  logic [6:0]  held;

  // Predicted results, oldest first.
  msg_t expected_msgs [$];

  // Number of data bytes that a status byte calls for.
  function automatic logic [1:0] data_bytes_after(input logic [7:0] s);
    logic [1:0] n;
    n = 2'd0;
    if (s[7:4] == HI_PROGRAM || s[7:4] == HI_CHAN_PRESSURE) n = 2'd1;
    else if (s[7:4] != HI_SYSTEM) n = 2'd2;
    else if (s == BYTE_MTC_QUARTER || s == BYTE_SONG_SELECT) n = 2'd1;
    else if (s == BYTE_SONG_POS) n = 2'd2;
    return n;
  endfunction

  function automatic void expect_short(input logic [7:0] st, input logic [6:0] d1,
                                       input logic [6:0] d2);
    msg_t m;
    if (!en.short_enable) return;
    m = '0;
    m.kind        = KIND_SHORT;
    m.status_byte = st;
    m.data_first  = d1;
    m.data_second = d2;
    expected_msgs.push_back(m);
  endfunction

  function automatic void expect_sysex(input kind_t k, input logic [7:0] b,
                                       input logic carried, input int unsigned len);
    msg_t m;
    if (!en.sysex_enable) return;
    m = '0;
    m.kind         = k;
    m.sysex_byte   = carried ? b : 8'h00;
    m.byte_valid   = carried;
    m.sysex_length = LEN_W'(len);
    expected_msgs.push_back(m);
  endfunction

  // State update for one received byte, with the result it should cause.
  task automatic parse_byte(input logic [7:0] b);
    logic [6:0] first;
    logic       room;
    if (b >= BYTE_REALTIME_MIN) return;
    if (b == BYTE_SYSEX_START) begin
      // A start byte opens a packet, or restarts one already open.
      in_packet  = 1'b1;
      packet_len = 1;
      run_status = STATUS_NONE;
      expect_sysex(KIND_SXBYTE, b, 1'b1, packet_len);
    end else if (b == BYTE_SYSEX_END) begin
      if (in_packet) begin
        room = (packet_len < SYSEX_CAPACITY);
        if (room) packet_len++;
        expect_sysex(KIND_SXEND, b, room, packet_len);
        in_packet  = 1'b0;
        packet_len = 0;
      end
    end else if (in_packet) begin
      // Everything else inside a packet is payload, until it overflows.
      if (packet_len < SYSEX_CAPACITY) begin
        packet_len++;
        expect_sysex(KIND_SXBYTE, b, 1'b1, packet_len);
      end else begin
        expect_sysex(KIND_SXABORT, b, 1'b0, packet_len);
        in_packet  = 1'b0;
        packet_len = 0;
      end
    end else if (b[7]) begin
      run_status = b;
      data_left  = data_bytes_after(b);
      held       = '0;
      if (data_left == 2'd0) expect_short(b, 7'd0, 7'd0);
    end else if (run_status != STATUS_NONE) begin
      if (data_left == 2'd2) begin
        held      = b[6:0];
        data_left = 2'd1;
      end else if (data_left == 2'd1) begin
        first     = held;
        data_left = data_bytes_after(run_status);
        held      = '0;
        expect_short(run_status, first, b[6:0]);
      end
    end
  endtask

  function automatic logic fields_match(input msg_t a, input msg_t b);
    return (a.kind === b.kind) && (a.status_byte === b.status_byte) &&
           (a.data_first === b.data_first) && (a.data_second === b.data_second) &&
           (a.sysex_byte === b.sysex_byte) && (a.byte_valid === b.byte_valid) &&
           (a.sysex_length === b.sysex_length);
  endfunction

  function automatic void report(input string what, input msg_t want, input msg_t got);
    errors++;
    if (errors <= REPORT_MAX) begin
      $display("%0t %s: expected kind %0d st %02h d1 %02h d2 %02h sx %02h bv %0b len %0d",
               $realtime, what, want.kind, want.status_byte, want.data_first,
               want.data_second, want.sysex_byte, want.byte_valid, want.sysex_length);
      $display("%0t %s:      got kind %0d st %02h d1 %02h d2 %02h sx %02h bv %0b len %0d",
               $realtime, what, got.kind, got.status_byte, got.data_first,
               got.data_second, got.sysex_byte, got.byte_valid, got.sysex_length);
    end
  endfunction

  // Watch the three channels at every rising edge.
  always @(posedge clk) begin
    msg_t got;
    msg_t want;
    if (rst) begin
      en          = '0;
      in_packet   = 1'b0;
      packet_len  = 0;
      run_status  = STATUS_NONE;
      data_left   = 2'd0;
      held        = '0;
      errors      = 0;
      expected_msgs.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_SHORT_ENABLE) en.short_enable = cfg.data[0];
        else if (cfg.index == REG_SYSEX_ENABLE) en.sysex_enable = cfg.data[0];
      end
      if (rx.valid && rx.ready) parse_byte(rx.rx_byte);
      if (result.valid && result.ready) begin
        got.kind         = kind_t'(result.kind);
        got.status_byte  = result.status_byte;
        got.data_first   = result.data_first;
        got.data_second  = result.data_second;
        got.sysex_byte   = result.sysex_byte;
        got.byte_valid   = result.byte_valid;
        got.sysex_length = result.sysex_length;
        if (expected_msgs.size() == 0) begin
          report("unexpected result", '0, got);
        end else begin
          want = expected_msgs.pop_front();
          if (!fields_match(want, got)) report("result mismatch", want, got);
        end
      end
    end
    outstanding = expected_msgs.size();
  end

endmodule

>>> dv/tb_midi_message_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI message parser testbench
// Drives received bytes and register writes into the parser and takes its
// results with random idling and one long receiver hold-off. A directed
// opening, three SysEx packets at and beyond capacity and random message
// traffic under several enable settings are checked by the result checker.
// ----------------------------------------------------------------------------
module tb_midi_message_parser;
  import mmp_pkg::*;

  localparam int unsigned CAPACITY      = 1024;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned IDLE_PERCENT  = 29;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam logic [7:0]  BYTE_UNDEF_F4 = 8'hF4;
  localparam logic [7:0]  BYTE_UNDEF_F5 = 8'hF5;
  localparam logic [7:0]  BYTE_TUNE_REQ = 8'hF6;
  localparam logic [7:0]  BYTE_REALTIME_MAX = 8'hFF;

  logic clk;
  logic rst;

  mmp_rx_if  rx_ch ();
  mmp_msg_if res_ch ();
  mmp_cfg_if cfg_ch ();

  int unsigned errors;
  int unsigned outstanding;
  int unsigned cycles;
  int unsigned items_sent;
  int unsigned stall_kick;
  int unsigned stall_seen;
  bit          gaps_on;
  logic [7:0]  prev_channel;

  midi_message_parser #(.SYSEX_CAPACITY(CAPACITY)) uut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  mmp_result_checker #(.SYSEX_CAPACITY(CAPACITY)) checker_i (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx_ch),
    .result      (res_ch),
    .cfg         (cfg_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run-length guard.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result receiver: random idling, plus one long hold-off on request.
  initial begin
    res_ch.ready = 1'b0;
    stall_seen   = 0;
    forever begin
      @(negedge clk);
      if (stall_kick != stall_seen) begin
        stall_seen = stall_kick;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      res_ch.ready <= (!gaps_on || $urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Offer one byte, called at a falling edge; returns at the falling edge
  // after the request was taken, with valid left high.
  task automatic put_byte(input logic [7:0] b);
    while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    @(negedge clk);
    if (b < BYTE_REALTIME_MIN) items_sent++;
  endtask

  // As put_byte, with an occasional real-time byte slipped in first.
  task automatic put_byte_rt(input logic [7:0] b);
    if ($urandom_range(99) < 6)
      put_byte(8'($urandom_range(BYTE_REALTIME_MIN, BYTE_REALTIME_MAX)));
    put_byte(b);
  endtask

  // Let the parser drain before touching its registers.
  task automatic wait_idle();
    rx_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_enables(input logic short_on, input logic sysex_on);
    wait_idle();
    write_reg(REG_SHORT_ENABLE, short_on);
    write_reg(REG_SYSEX_ENABLE, sysex_on);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    if ($urandom_range(7) == 0) begin
      b = 8'($urandom_range(8'h80, BYTE_TUNE_REQ));
      if (b == BYTE_SYSEX_START) b = BYTE_MTC_QUARTER;
    end else begin
      b = 8'($urandom_range(8'h7F));
    end
    return b;
  endfunction

  // Start byte, n payload bytes and, if asked, the end byte.
  task automatic sysex_packet(input int unsigned n, input bit closed);
    put_byte_rt(BYTE_SYSEX_START);
    repeat (n) put_byte_rt(payload_byte());
    if (closed) put_byte_rt(BYTE_SYSEX_END);
  endtask

  // Directed opening: field extremes, several message classes, corner cases.
  task automatic opening_bytes();
    logic [7:0] seq [$];
    seq = '{8'h55,                                         // data with no status
            {HI_NOTE_ON, 4'h0}, 8'h3C, 8'h7F,
            8'h00, 8'h00,                                  // running status
            BYTE_REALTIME_MIN,
            {HI_PROGRAM, 4'hF}, 8'h7F, 8'h00,
            BYTE_MTC_QUARTER, 8'h7F,
            BYTE_SONG_POS, 8'h01, 8'h02,
            BYTE_SONG_SELECT, 8'h00,
            BYTE_UNDEF_F4, 8'h12,                          // data after a bare status
            BYTE_SYSEX_END,                                // end with no packet open
            BYTE_REALTIME_MAX,
            BYTE_SYSEX_START, 8'h00, {HI_PITCH_BEND, 4'h3}, 8'h7F,
            BYTE_SYSEX_START, BYTE_SYSEX_END,              // restart inside a packet
            {HI_PITCH_BEND, 4'hF}, 8'h7F, 8'h7F};
    foreach (seq[i]) put_byte(seq[i]);
  endtask

  // One random message, mostly well formed.
  task automatic random_sequence();
    int unsigned pick;
    int unsigned n;
    int unsigned reps;
    logic [7:0]  st;
    pick = $urandom_range(99);
    if (pick < 45) begin
      // Channel message, sometimes leaning on running status.
      if (prev_channel != 8'h00 && $urandom_range(3) == 0) begin
        st = prev_channel;
      end else begin
        st = {4'(HI_NOTE_OFF + $urandom_range(6)), 4'($urandom_range(15))};
        put_byte_rt(st);
        prev_channel = st;
      end
      n    = (st[7:4] == HI_PROGRAM || st[7:4] == HI_CHAN_PRESSURE) ? 1 : 2;
      reps = $urandom_range(1, 3);
      repeat (reps * n) put_byte_rt(8'($urandom_range(8'h7F)));
    end else if (pick < 57) begin
      // System common message.
      case ($urandom_range(5))
        0: begin st = BYTE_MTC_QUARTER; n = 1; end
        1: begin st = BYTE_SONG_SELECT; n = 1; end
        2: begin st = BYTE_SONG_POS;    n = 2; end
        3: begin st = BYTE_UNDEF_F4;    n = 0; end
        4: begin st = BYTE_UNDEF_F5;    n = 0; end
        default: begin st = BYTE_TUNE_REQ; n = 0; end
      endcase
      put_byte_rt(st);
      reps = (n == 0) ? $urandom_range(1) : $urandom_range(1, 2);
      repeat ((n == 0) ? reps : reps * n) put_byte_rt(8'($urandom_range(8'h7F)));
    end else if (pick < 78) begin
      // Short SysEx packet, now and then left open.
      sysex_packet($urandom_range(12), $urandom_range(9) != 0);
    end else begin
      put_byte_rt(8'($urandom_range(255)));
    end
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) random_sequence();
  endtask

  // Stimulus and verdict.
  initial begin
    rst           = 1'b1;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = REG_SHORT_ENABLE;
    cfg_ch.data   = 1'b0;
    gaps_on       = 1'b1;
    stall_kick    = 0;
    items_sent    = 0;
    prev_channel  = 8'h00;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_enables(1'b1, 1'b1);
    opening_bytes();

    // Packets at capacity: overflow, end without room, end that just fits.
    sysex_packet(CAPACITY, 1'b0);
    sysex_packet(CAPACITY - 1, 1'b1);
    sysex_packet(CAPACITY - 2, 1'b1);

    // Back-to-back traffic with the receiver held off for a while.
    set_enables(1'b1, 1'b1);
    gaps_on    = 1'b0;
    stall_kick = stall_kick + 1;
    random_phase(110);
    gaps_on = 1'b1;
    random_phase(60);

    set_enables(1'b0, 1'b1);
    random_phase(70);
    set_enables(1'b1, 1'b0);
    random_phase(70);
    set_enables(1'b0, 1'b0);
    random_phase(50);
    set_enables(1'b1, 1'b1);
    random_phase(90);

    wait_idle();
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/mmp_pkg.sv
rtl/mmp_if.sv
rtl/mmp_step.sv
rtl/mmp_out_reg.sv
rtl/midi_message_parser.sv
dv/mmp_result_checker.sv
dv/tb_midi_message_parser.sv
